// ===== hw/rtl/signed_int_to_decimal_ascii_assert.svh =====
// Assertion macros for the checker file of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Checked at every rising edge outside reset.
`define S2D_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define S2D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/s2d_pkg.sv =====
// Package: widths and character codes of the decimal text converter.
`default_nettype none

package s2d_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned NumDigits  = 10;
  localparam int unsigned BcdWidth   = 4 * NumDigits;
  localparam int unsigned ShiftCntW  = $clog2(ValueWidth + 1);
  localparam int unsigned DigitCntW  = $clog2(NumDigits + 1);

  localparam logic [7:0] CharMinus = 8'd45;
  localparam logic [7:0] CharZero  = 8'd48;

  // Status from the converter to the control logic.
  typedef struct packed {
    logic                busy;
    logic [BcdWidth-1:0] bcd;
  } s2d_conv_t;

endpackage

`default_nettype wire

// ===== hw/rtl/s2d_dabble.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
`default_nettype none

module s2d_dabble import s2d_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [ValueWidth-1:0] mag_i,
  output s2d_conv_t                  status_o
);

  logic                 busy_q, busy_d;
  logic [ShiftCntW-1:0] cnt_q, cnt_d;
  logic [ValueWidth-1:0] bin_q, bin_d;
  logic [BcdWidth-1:0]  bcd_q, bcd_d;
  logic [BcdWidth-1:0]  bcd_adj;

  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ShiftCntW'(ValueWidth);
      bin_d  = mag_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BcdWidth-2:0], bin_q[ValueWidth-1]};
      bin_d = {bin_q[ValueWidth-2:0], 1'b0};
      cnt_d = cnt_q - ShiftCntW'(1);
      if (cnt_q == ShiftCntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.bcd  = bcd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// A value passes through bit-serial BCD conversion (StConv), a leading-zero scan
// (StSkip) and the emit state (StEmit), which sends the sign, if any, then the digits.
// A new value is not taken until the last character of the previous one is in the
// output register; one character leaves per cycle while out_ready_i is high.
// in_ready_o is high only between items; the output register holds the last character.
// Reset (async, active low) empties the output register and returns control to idle.
`default_nettype none

module signed_int_to_decimal_ascii import s2d_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [ValueWidth-1:0] value_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic [7:0]            character_o,
  output      logic                  last_o
);

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StSkip,
    StEmit
  } state_e;

  state_e               state_q;
  logic                 neg_q;
  logic [DigitCntW-1:0] dcnt_q;
  logic [BcdWidth-1:0]  digits_q;
  logic                 out_valid_q;
  logic [7:0]           char_q;
  logic                 last_q;

  logic                  in_acc;
  logic                  out_free;
  logic [ValueWidth-1:0] mag;
  logic [3:0]            top_digit;
  s2d_conv_t             conv;

  assign in_acc    = in_valid_i && (state_q == StIdle);
  assign out_free  = !out_valid_q || out_ready_i;
  assign mag       = value_i[ValueWidth-1] ? (ValueWidth'(0) - value_i) : value_i;
  assign top_digit = digits_q[BcdWidth-1 -: 4];

  s2d_dabble u_dabble (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (in_acc),
    .mag_i    (mag),
    .status_o (conv)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      neg_q       <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // in StEmit the emit branch below owns out_valid_q
      if (out_valid_q && out_ready_i && state_q != StEmit) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            neg_q   <= value_i[ValueWidth-1];
            state_q <= StConv;
          end
        end
        StConv: begin
          if (!conv.busy) begin
            dcnt_q  <= DigitCntW'(NumDigits);
            state_q <= StSkip;
          end
        end
        StSkip: begin
          // drop leading zeros, keeping at least one digit
          if (top_digit == 4'd0 && dcnt_q > DigitCntW'(1)) begin
            dcnt_q <= dcnt_q - DigitCntW'(1);
          end else begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (neg_q) begin
              neg_q <= 1'b0;
            end else begin
              dcnt_q <= dcnt_q - DigitCntW'(1);
              if (dcnt_q == DigitCntW'(1)) begin
                state_q <= StIdle;
              end
            end
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  // payload: digit shifter and output character register
  always_ff @(posedge clk_i) begin
    if (state_q == StConv && !conv.busy) begin
      digits_q <= conv.bcd;
    end else if (state_q == StSkip && top_digit == 4'd0 && dcnt_q > DigitCntW'(1)) begin
      digits_q <= {digits_q[BcdWidth-5:0], 4'd0};
    end else if (state_q == StEmit && out_free && !neg_q) begin
      digits_q <= {digits_q[BcdWidth-5:0], 4'd0};
    end
    if (state_q == StEmit && out_free) begin
      if (neg_q) begin
        char_q <= CharMinus;
        last_q <= 1'b0;
      end else begin
        char_q <= CharZero + {4'd0, top_digit};
        last_q <= (dcnt_q == DigitCntW'(1));
      end
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== hw/rtl/s2d_checker.sv =====
// Port checker for the decimal text converter, bound to the top level.
`default_nettype none

`include "signed_int_to_decimal_ascii_assert.svh"

module s2d_checker import s2d_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic [ValueWidth-1:0] value_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic [7:0]            character_o,
  input wire logic                  last_o
);

  `S2D_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(character_o) && $stable(last_o), "stalled item changed")

  `S2D_ASSERT(a_char_code, clk_i, rst_ni, out_valid_o |-> character_o == CharMinus || (character_o >= CharZero && character_o <= CharZero + 8'd9), "character is not a sign or digit")

  `S2D_ASSERT(a_minus_not_last, clk_i, rst_ni, out_valid_o && character_o == CharMinus |-> !last_o, "sign marked as last")

  `S2D_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "ready after accepting an item")

endmodule

bind signed_int_to_decimal_ascii s2d_checker u_s2d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .value_i     (value_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .character_o (character_o),
  .last_o      (last_o)
);

`default_nettype wire

// ===== tb/sv/s2d_text_checker.sv =====
`timescale 1ns / 1ps
// Checker: predicts the character run of each accepted value and compares the output items.
module s2d_text_checker import s2d_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [ValueWidth-1:0] value_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [7:0]            character_i,
  input  logic                  last_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int unsigned Radix = 10;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } text_char_t;

  text_char_t expected_text [$];
  int         fail_count = 0;

  initial pending_o = 0;

  assign fail_count_o = fail_count;

  // Appends the decimal text of one value, most significant character first.
  task automatic queue_decimal_text(input logic [ValueWidth-1:0] value);
    logic [ValueWidth-1:0] magnitude;
    logic [7:0]            digits [$];
    text_char_t            entry;
    // unsigned negate, so the most negative value keeps its full magnitude
    magnitude = value[ValueWidth-1] ? -value : value;
    do begin
      digits.push_front(CharZero + 8'(magnitude % Radix));
      magnitude = magnitude / Radix;
    end while (magnitude != 0);
    if (value[ValueWidth-1]) begin
      entry.character = CharMinus;
      entry.last      = 1'b0;
      expected_text.push_back(entry);
    end
    foreach (digits[i]) begin
      entry.character = digits[i];
      entry.last      = (i == digits.size() - 1);
      expected_text.push_back(entry);
    end
  endtask

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        queue_decimal_text(value_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_text.size() == 0) begin
          $error("unexpected item: character %0d, last %0b", character_i, last_i);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (character_i !== want.character) begin
            $error("character: expected %0d, actual %0d", want.character, character_i);
            fail_count++;
          end
          if (last_i !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last_i);
            fail_count++;
          end
        end
      end
    end
    pending_o <= expected_text.size();
  end

endmodule

// ===== tb/sv/signed_int_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, stimulus and verdict for the decimal text converter.
module signed_int_to_decimal_ascii_tb;
  import s2d_pkg::*;

  localparam int unsigned NumRandom   = 129;
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 60;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [ValueWidth-1:0] value_i     = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [7:0]            character_o;
  logic                  last_o;

  int          fail_count;
  int          pending;
  bit          run_done = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned ready_run = 0;
  int unsigned burst_left = 0;

  int corner_values [] = '{
    0, 1, -1, 9, -9, 10, -10, 99, -100, 1000, 123456789, -987654321,
    999999999, -999999999, 1000000000, -1000000000, 2147483647, -2147483647,
    32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA
  };

  signed_int_to_decimal_ascii dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  s2d_text_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .value_i     (value_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .character_i (character_o),
    .last_i      (last_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Output backpressure: short stalls, occasional long ones, and long runs of ready.
  always @(posedge clk_i) begin
    if (ready_run != 0) begin
      ready_run <= ready_run - 1;
    end else begin
      case ($urandom_range(9))
        0, 1, 2: begin
          out_ready_i <= 1'b0;
          ready_run   <= $urandom_range(3);
        end
        3: begin
          out_ready_i <= 1'b0;
          ready_run   <= $urandom_range(60, 20);
        end
        4: begin
          out_ready_i <= 1'b1;
          ready_run   <= $urandom_range(200, 50);
        end
        default: begin
          out_ready_i <= 1'b1;
          ready_run   <= $urandom_range(4);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !run_done) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Holds valid across back-to-back items; lowers it only when a gap follows.
  task automatic send_value(input logic [ValueWidth-1:0] value, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    int unsigned gap;
    int unsigned num_digits;
    longint      lo;
    longint      hi;
    longint      magnitude;
    bit          negative;
    logic [ValueWidth-1:0] value;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_values[i]) begin
      send_value(corner_values[i], $urandom_range(3) == 0 ? $urandom_range(5, 1) : 0);
    end

    for (int n = 0; n < NumRandom; n++) begin
      negative = $urandom_range(1);
      case ($urandom_range(3))
        0: value = $urandom;
        1: begin
          // magnitude with a chosen number of digits, so every run length shows up
          num_digits = $urandom_range(10, 1);
          lo = 1;
          repeat (num_digits - 1) lo = lo * 10;
          hi = lo * 10 - 1;
          if (num_digits == 1) lo = 0;
          if (hi > 64'd2147483647) hi = negative ? 64'd2147483648 : 64'd2147483647;
          magnitude = lo + longint'($urandom_range(32'(hi - lo)));
          value = negative ? -32'(magnitude) : 32'(magnitude);
        end
        2: begin
          // next to a power of ten
          magnitude = 1;
          repeat ($urandom_range(9)) magnitude = magnitude * 10;
          magnitude = magnitude + $urandom_range(2) - 1;
          value = negative ? -32'(magnitude) : 32'(magnitude);
        end
        default: value = $urandom_range(40) - 20;
      endcase

      if (burst_left != 0) begin
        burst_left = burst_left - 1;
        gap = 0;
      end else begin
        case ($urandom_range(11))
          0:             begin burst_left = $urandom_range(12, 4); gap = 0; end
          1, 2, 3, 4, 5: gap = 0;
          6, 7, 8, 9:    gap = $urandom_range(3, 1);
          default:       gap = $urandom_range(80, 20);
        endcase
      end
      send_value(value, gap);
    end
    in_valid_i <= 1'b0;

    // the count from the last accept is registered in the checker before it can be read
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    run_done = 1'b1;
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
